FILE: sv/ecgf_pkg.sv
package ecgf_pkg;

    // Record constants
    localparam logic [7:0] SYNC_A   = 8'hA5;
    localparam logic [7:0] SYNC_B   = 8'hEC;
    localparam logic [7:0] REC_TYPE = 8'h01;
    localparam logic [7:0] CRC_POLY = 8'h07;

    // Byte positions inside the 12-byte record
    localparam int unsigned IDX_W = 4;
    localparam logic [IDX_W-1:0] POS_SYNC_A = 4'd0;
    localparam logic [IDX_W-1:0] POS_SYNC_B = 4'd1;
    localparam logic [IDX_W-1:0] POS_TYPE   = 4'd2;
    localparam logic [IDX_W-1:0] POS_TAGS   = 4'd3;
    localparam logic [IDX_W-1:0] POS_SEQ0   = 4'd4;
    localparam logic [IDX_W-1:0] POS_SEQ1   = 4'd5;
    localparam logic [IDX_W-1:0] POS_SEQ2   = 4'd6;
    localparam logic [IDX_W-1:0] POS_SEQ3   = 4'd7;
    localparam logic [IDX_W-1:0] POS_RAW2   = 4'd8;
    localparam logic [IDX_W-1:0] POS_RAW1   = 4'd9;
    localparam logic [IDX_W-1:0] POS_RAW0   = 4'd10;
    localparam logic [IDX_W-1:0] POS_CRC    = 4'd11;

    // One framed sample, as it waits between front and back
    typedef struct packed {
        logic [23:0] raw;
        logic [2:0]  ptag;
        logic [2:0]  etag;
        logic [31:0] seq;
    } ecgf_rec_t;

    // Front to queue push
    typedef struct packed {
        logic      valid;
        ecgf_rec_t rec;
    } ecgf_push_t;

    // CRC-8, poly 0x07, MSB first, one byte
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++)
        begin
            if (c[7])
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[6:0], 1'b0};
        end
        return c;
    endfunction

endpackage

FILE: sv/ecgf_front.sv
module ecgf_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [31:0]          s_tdata,   // raw_sample[23:0], etag[26:24], ptag[29:27], pad
    input  logic [1:0]           s_tuser,   // sample_valid[0], new_session[1]
    input  logic                 q_full,
    output ecgf_pkg::ecgf_push_t push
);

    logic [31:0] seq_reg;
    logic [31:0] seq_next;
    logic [31:0] seq_cur;
    logic        accept;

    // Sample word is taken whenever the queue has room
    assign s_tready = !q_full;
    assign accept   = s_tvalid && !q_full;

    // Sequence number used by this sample, after a session clear
    assign seq_cur = s_tuser[1] ? 32'd0 : seq_reg;

    always_comb
    begin
        seq_next = seq_reg;
        if (accept)
            seq_next = s_tuser[0] ? seq_cur + 32'd1 : seq_cur;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            seq_reg <= 32'd0;
        else
            seq_reg <= seq_next;
    end

    // Only real samples become records
    assign push.valid    = accept && s_tuser[0];
    assign push.rec.raw  = s_tdata[23:0];
    assign push.rec.etag = s_tdata[26:24];
    assign push.rec.ptag = s_tdata[29:27];
    assign push.rec.seq  = seq_cur;

    // Dropped samples never advance the count
    a_drop_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !s_tuser[0] && !s_tuser[1]) |=> (seq_reg == $past(seq_reg)))
        else $error("count moved on a dropped sample");

endmodule

FILE: sv/ecgf_queue.sv
module ecgf_queue #(
    parameter int unsigned DEPTH = 2
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ecgf_pkg::ecgf_push_t push,
    output logic                 full,
    output logic                 head_valid,
    output ecgf_pkg::ecgf_rec_t  head,
    input  logic                 pop
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    ecgf_pkg::ecgf_rec_t mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             do_push;
    logic             do_pop;

    assign full       = (cnt_reg == CNT_FULL);
    assign head_valid = (cnt_reg != '0);
    assign head       = mem[rd_ptr_reg];
    assign do_push    = push.valid && !full;
    assign do_pop     = pop && head_valid;

    // Storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push.rec;
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                cnt_reg <= cnt_reg + 1'b1;
            else if (!do_push && do_pop)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push.valid |-> !full)
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("pop from empty queue");

endmodule

FILE: sv/ecgf_back.sv
module ecgf_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                head_valid,
    input  ecgf_pkg::ecgf_rec_t head,
    output logic                pop,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [7:0]          m_tdata,   // frame_byte[7:0]
    output logic                m_tlast
);

    logic [ecgf_pkg::IDX_W-1:0] idx_reg;
    logic [7:0]                 crc_reg;
    logic                       m_tvalid_reg;
    logic [7:0]                 m_tdata_reg;
    logic                       m_tlast_reg;
    logic                       advance;
    logic                       in_crc_span;
    logic                       at_end;
    logic [7:0]                 byte_sel;

    // Output register frees up when empty or taken this cycle
    assign advance     = head_valid && (!m_tvalid_reg || m_tready);
    assign at_end      = (idx_reg == ecgf_pkg::POS_CRC);
    assign in_crc_span = (idx_reg >= ecgf_pkg::POS_TYPE) && (idx_reg <= ecgf_pkg::POS_RAW0);
    assign pop         = advance && at_end;

    // Byte picker for the current record position
    always_comb
    begin
        unique case (idx_reg)
            ecgf_pkg::POS_SYNC_A: byte_sel = ecgf_pkg::SYNC_A;
            ecgf_pkg::POS_SYNC_B: byte_sel = ecgf_pkg::SYNC_B;
            ecgf_pkg::POS_TYPE:   byte_sel = ecgf_pkg::REC_TYPE;
            ecgf_pkg::POS_TAGS:   byte_sel = {2'b00, head.ptag, head.etag};
            ecgf_pkg::POS_SEQ0:   byte_sel = head.seq[7:0];
            ecgf_pkg::POS_SEQ1:   byte_sel = head.seq[15:8];
            ecgf_pkg::POS_SEQ2:   byte_sel = head.seq[23:16];
            ecgf_pkg::POS_SEQ3:   byte_sel = head.seq[31:24];
            ecgf_pkg::POS_RAW2:   byte_sel = head.raw[23:16];
            ecgf_pkg::POS_RAW1:   byte_sel = head.raw[15:8];
            ecgf_pkg::POS_RAW0:   byte_sel = head.raw[7:0];
            ecgf_pkg::POS_CRC:    byte_sel = crc_reg;
            default:              byte_sel = 8'h00;
        endcase
    end

    // Position counter, running CRC, output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg      <= ecgf_pkg::POS_SYNC_A;
            crc_reg      <= 8'h00;
            m_tvalid_reg <= 1'b0;
        end
        else if (advance)
        begin
            m_tvalid_reg <= 1'b1;
            if (at_end)
            begin
                idx_reg <= ecgf_pkg::POS_SYNC_A;
                crc_reg <= 8'h00;
            end
            else
            begin
                idx_reg <= idx_reg + 1'b1;
                if (in_crc_span)
                    crc_reg <= ecgf_pkg::crc8_byte(crc_reg, byte_sel);
            end
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            m_tdata_reg <= byte_sel;
            m_tlast_reg <= at_end;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg <= ecgf_pkg::POS_CRC)
        else $error("record position out of range");

    a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> (idx_reg == ecgf_pkg::POS_SYNC_A) && (crc_reg == 8'h00))
        else $error("frame end did not rewind position and crc");

    a_first_byte: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && idx_reg == ecgf_pkg::POS_SYNC_A) |=>
            (m_tvalid && m_tdata == ecgf_pkg::SYNC_A && !m_tlast))
        else $error("frame does not open with sync byte");

endmodule

FILE: sv/ecg_sample_framer_crc8.sv
// channel | dir | tdata                                  | tuser                         | tlast
// s_*     | in  | raw_sample[23:0] etag[26:24] ptag[29:27] | sample_valid[0] new_session[1] | -
// m_*     | out | frame_byte[7:0]                         | -                             | frame_last
//
// Each valid sample gives 12 words, one per cycle while m_tready holds; a new frame
// follows the previous one with no gap when the queue holds the next record; the single-byte
// output serializer sets the pace. Dropped samples are accepted but never queued.
// The front keeps taking samples while the record queue has room (QUEUE_DEPTH).
// Reset clears the sequence count, queue and output valid; no warm-up pass.
// A stall on m_tready holds the word in the output register and backs up the queue.
module ecg_sample_framer_crc8 #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // raw_sample[23:0], etag[26:24], ptag[29:27], zero pad
    input  logic [1:0]  s_tuser,   // sample_valid[0], new_session[1]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // frame_byte[7:0]
    output logic        m_tlast    // frame_last
);

    ecgf_pkg::ecgf_push_t push;
    ecgf_pkg::ecgf_rec_t  head;
    logic                 q_full;
    logic                 head_valid;
    logic                 pop;

    // Front: count and record build
    ecgf_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .push     (push)
    );

    // Record queue
    ecgf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (q_full),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop)
    );

    // Back: byte serializer with CRC
    ecgf_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

endmodule
